### design/arm_elf_relocation_patcher_assert.svh
// Assertion macros used by the port-level checker of the relocation patcher.
`ifndef ARM_ELF_RELOCATION_PATCHER_ASSERT_SVH
`define ARM_ELF_RELOCATION_PATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AERP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aerp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AERP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aerp check failed");

// Next-cycle implication that stays live through reset.
`define AERP_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("aerp reset check failed");

`endif

### design/aerp_pkg.sv
// Types and constants of the ARM ELF relocation patcher.
`default_nettype none

package aerp_pkg;

    typedef enum logic [4:0] {
        A_NONE       = 5'd0,
        A_PREL31     = 5'd1,
        A_PC24       = 5'd2,
        A_CALL       = 5'd3,
        A_JUMP24     = 5'd4,
        A_V4BX       = 5'd5,
        A_MOVT       = 5'd6,
        A_MOVW       = 5'd7,
        A_REL32      = 5'd8,
        A_ABS32      = 5'd9,
        A_GLOB_DAT   = 5'd10,
        A_THM_MOVT   = 5'd11,
        A_THM_MOVW   = 5'd12,
        A_THM_JUMP24 = 5'd13,
        A_THM_CALL   = 5'd14,
        A_THM_JUMP19 = 5'd15,
        A_THM_ABS5   = 5'd16,
        A_THM_JUMP6  = 5'd17,
        A_THM_JUMP11 = 5'd18,
        A_THM_JUMP8  = 5'd19
    } t_aerp_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_INTERWORK = 2'd2,
        ST_UNKNOWN   = 2'd3
    } t_aerp_status;

    // ARM BLX / BL opcode tops
    localparam logic [7:0] BLX_TOP    = 8'hfa;
    localparam logic [6:0] BLX_MASKED = 7'h7d;
    localparam logic [7:0] BL_AL_TOP  = 8'heb;
    // Thumb B<cond> with cond bits all set is not a conditional branch
    localparam logic [2:0] T2_COND_AL = 3'b111;

    typedef struct packed {
        t_aerp_action action;
        logic [31:0]  word;
        logic [31:0]  sum;     // S + A
        logic [31:0]  place;
        logic         thumb;
        t_aerp_status status;  // early status from decode
    } t_aerp_entry;

    typedef struct packed {
        logic        valid;
        t_aerp_entry entry;
    } t_aerp_qport;

endpackage

`default_nettype wire

### design/arm_elf_relocation_patcher.sv
// Top level of the ARM ELF REL relocation patcher.
// Usage:
//   Input side is a queue: drive action, place_word, symbol_value and
//   place_address with push; a request is taken at a clock edge where push
//   is high and full is low.
//   Output side is a queue: while empty is low, patched_word and status show
//   the oldest result; pulse pop to take it.
//   A request taken passes through the decode queue, then the output register, which shows its result.
//   Throughput: one request per cycle while full is low, set by the single add in the front
//   end and the single subtract and repack in the back end.
//   The decode queue holds P_QDEPTH requests; with the output register the
//   block holds P_QDEPTH + 1 before full rises.
//   When the receiver stalls, the result holds and the queue fills; full
//   rises once it is full and drops the cycle after the next pop.
//   Reset (synchronous, active low) empties the queue and output register;
//   no other state exists, so requests may follow right after reset.
`default_nettype none

module arm_elf_relocation_patcher
    import aerp_pkg::*;
#(
    parameter int P_QDEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [4:0]  i_action,
    input  wire logic [31:0] i_place_word,
    input  wire logic [31:0] i_symbol_value,
    input  wire logic [31:0] i_place_address,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_patched_word,
    output logic [1:0]       o_status
);

    t_aerp_qport q_wr;
    t_aerp_qport q_rd;
    logic        q_full;
    logic        q_take;

    aerp_front u_front (
        .i_push          (push),
        .i_q_full        (q_full),
        .i_action        (i_action),
        .i_place_word    (i_place_word),
        .i_symbol_value  (i_symbol_value),
        .i_place_address (i_place_address),
        .o_wr            (q_wr)
    );

    aerp_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_take  (q_take)
    );

    aerp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd           (q_rd),
        .o_take         (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_patched_word (o_patched_word),
        .o_status       (o_status)
    );

    assign full = q_full;

endmodule

`default_nettype wire

### design/aerp_front.sv
// Front end: decodes the relocation, extracts the addend and forms S + A.
`default_nettype none

module aerp_front
    import aerp_pkg::*;
(
    input  wire logic        i_push,
    input  wire logic        i_q_full,
    input  wire logic [4:0]  i_action,
    input  wire logic [31:0] i_place_word,
    input  wire logic [31:0] i_symbol_value,
    input  wire logic [31:0] i_place_address,
    output t_aerp_qport      o_wr
);

    t_aerp_action act;
    logic [31:0]  w;
    logic [31:0]  addend;
    logic         thumb;
    logic         sg;
    logic         j1;
    logic         j2;
    t_aerp_status early;

    assign act   = t_aerp_action'(i_action);
    assign w     = i_place_word;
    assign thumb = i_symbol_value[0];
    assign sg    = w[10];
    assign j1    = ~(w[29] ^ sg);
    assign j2    = ~(w[27] ^ sg);

    always_comb begin
        unique case (act)
            A_PREL31:
                addend = {w[30], w[30:0]};
            A_PC24, A_CALL, A_JUMP24:
                addend = {{6{w[23]}}, w[23:0], 2'b00};
            A_MOVT, A_MOVW:
                addend = {{16{w[19]}}, w[19:16], w[11:0]};
            A_REL32, A_ABS32, A_GLOB_DAT:
                addend = w;
            A_THM_MOVT, A_THM_MOVW:
                addend = {{16{w[3]}}, w[3:0], w[10], w[30:28], w[23:16]};
            A_THM_JUMP24, A_THM_CALL:
                addend = {{7{sg}}, sg, j1, j2, w[9:0], w[26:16], 1'b0};
            A_THM_JUMP19:
                addend = {{11{sg}}, sg, w[27], w[29], w[5:0], w[26:16], 1'b0};
            A_THM_ABS5:
                addend = {25'd0, w[10:6], 2'b00};
            A_THM_JUMP6:
                addend = {25'd0, w[9], w[7:3], 1'b0};
            A_THM_JUMP11:
                addend = {{20{w[10]}}, w[10:0], 1'b0};
            A_THM_JUMP8:
                addend = {{23{w[7]}}, w[7:0], 1'b0};
            default:
                addend = '0;
        endcase
    end

    // Interworking and encoding errors known before any arithmetic
    always_comb begin
        unique case (act)
            A_PC24, A_CALL, A_JUMP24:
                early = (thumb && (w[31:25] != BLX_MASKED) && (w[31:24] != BL_AL_TOP))
                        ? ST_INTERWORK : ST_OK;
            A_THM_JUMP24:
                early = thumb ? ST_OK : ST_INTERWORK;
            A_THM_JUMP19:
                early = !thumb ? ST_INTERWORK :
                        (w[9:7] == T2_COND_AL) ? ST_UNKNOWN : ST_OK;
            A_NONE, A_PREL31, A_V4BX, A_MOVT, A_MOVW, A_REL32, A_ABS32, A_GLOB_DAT,
            A_THM_MOVT, A_THM_MOVW, A_THM_CALL, A_THM_ABS5, A_THM_JUMP6,
            A_THM_JUMP11, A_THM_JUMP8:
                early = ST_OK;
            default:
                early = ST_UNKNOWN;
        endcase
    end

    always_comb begin
        o_wr.valid        = i_push && !i_q_full;
        o_wr.entry.action = act;
        o_wr.entry.word   = w;
        o_wr.entry.sum    = i_symbol_value + addend;
        o_wr.entry.place  = i_place_address;
        o_wr.entry.thumb  = thumb;
        o_wr.entry.status = early;
    end

endmodule

`default_nettype wire

### design/aerp_queue.sv
// Short queue of decoded relocations between front and back end.
`default_nettype none

module aerp_queue
    import aerp_pkg::*;
#(
    parameter int P_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_aerp_qport i_wr,
    output logic             o_full,
    output t_aerp_qport      o_rd,
    input  wire logic        i_take
);

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_aerp_entry    r_slot [P_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  n_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW-1:0]  n_rptr;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           do_wr;
    logic           do_rd;

    assign o_full     = (r_count == CW'(P_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_slot[r_rptr];
    assign do_wr      = i_wr.valid && !o_full;
    assign do_rd      = i_take && o_rd.valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PW'(P_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PW'(P_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wptr] <= i_wr.entry;
        end
    end

endmodule

`default_nettype wire

### design/aerp_back.sv
// Back end: subtracts P for PC-relative types, checks range, repacks the fields and holds the result.
`default_nettype none

module aerp_back
    import aerp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_aerp_qport i_rd,
    output logic             o_take,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [31:0]      o_patched_word,
    output logic [1:0]       o_status
);

    t_aerp_entry  e;
    logic [31:0]  w;
    logic [15:0]  up;
    logic [15:0]  lo;
    logic [15:0]  lo_call;
    logic [15:0]  half;
    logic         use_t;
    logic         use_p;
    logic [31:0]  y;
    logic [31:0]  x;
    logic [7:0]   ins_top;
    logic [31:0]  packed_word;
    t_aerp_status st;
    logic         r_valid;
    logic         n_valid;
    logic [31:0]  r_word;
    logic [31:0]  n_word;
    t_aerp_status r_status;
    t_aerp_status n_status;

    assign e  = i_rd.entry;
    assign w  = e.word;
    assign up = w[15:0];
    assign lo = w[31:16];

    always_comb begin
        use_t = (e.action == A_PREL31) || (e.action == A_REL32) ||
                (e.action == A_ABS32) || (e.action == A_GLOB_DAT);
        use_p = (e.action == A_PREL31) || (e.action == A_PC24) || (e.action == A_CALL) ||
                (e.action == A_JUMP24) || (e.action == A_REL32) ||
                (e.action == A_THM_JUMP24) || (e.action == A_THM_CALL) ||
                (e.action == A_THM_JUMP19) || (e.action == A_THM_JUMP6) ||
                (e.action == A_THM_JUMP11) || (e.action == A_THM_JUMP8);
        y = use_t ? {e.sum[31:1], e.sum[0] | e.thumb} : e.sum;
        x = use_p ? y - e.place : y;
    end

    // Thumb BL to an ARM target becomes BLX: clear bit 12 of the second halfword
    assign lo_call = (e.action == A_THM_CALL && !e.thumb) ? {lo[15:13], 1'b0, lo[11:0]} : lo;
    // ARM BL with Thumb target becomes BLX
    assign ins_top = (e.thumb && (w[31:25] != BLX_MASKED)) ? BLX_TOP : w[31:24];
    assign half    = (e.action == A_THM_MOVT || e.action == A_MOVT) ? x[31:16] : x[15:0];

    always_comb begin
        st          = e.status;
        packed_word = w;
        unique case (e.action)
            A_PREL31: begin
                if (x[31] != x[30]) st = ST_OVERFLOW;
                packed_word = {w[31], x[30:0]};
            end
            A_PC24, A_CALL, A_JUMP24:
                packed_word = {ins_top, x[25:2]};
            A_MOVT, A_MOVW:
                packed_word = {w[31:20], half[15:12], w[15:12], half[11:0]};
            A_REL32, A_ABS32, A_GLOB_DAT:
                packed_word = x;
            A_THM_MOVT, A_THM_MOVW:
                packed_word = {lo[15], half[10:8], lo[11:8], half[7:0],
                               up[15:11], half[11], up[9:4], half[15:12]};
            A_THM_JUMP24, A_THM_CALL: begin
                if (x[31:24] != {8{x[24]}}) st = ST_OVERFLOW;
                packed_word = {lo_call[15:14], x[24] ^ ~x[23], lo_call[12],
                               x[24] ^ ~x[22], x[11:1],
                               up[15:11], x[24], x[21:12]};
            end
            A_THM_JUMP19: begin
                if (x[31:20] != {12{x[20]}}) st = ST_OVERFLOW;
                packed_word = {lo[15:14], x[18], lo[12], x[19], x[11:1],
                               up[15:11], x[20], up[9:6], x[17:12]};
            end
            A_THM_ABS5: begin
                if (x[31:7] != '0) st = ST_OVERFLOW;
                packed_word = {w[31:11], x[6:2], w[5:0]};
            end
            A_THM_JUMP6: begin
                if (x[31:7] != '0) st = ST_OVERFLOW;
                packed_word = {w[31:10], x[6], w[8], x[5:1], w[2:0]};
            end
            A_THM_JUMP11: begin
                if (x[31:11] != {21{x[11]}}) st = ST_OVERFLOW;
                packed_word = {w[31:11], x[11:1]};
            end
            A_THM_JUMP8: begin
                if (x[31:8] != {24{x[8]}}) st = ST_OVERFLOW;
                packed_word = {w[31:8], x[8:1]};
            end
            default:
                packed_word = w;
        endcase
        // early errors take priority over a range check
        if (e.status != ST_OK) st = e.status;
    end

    assign o_take = i_rd.valid && (!r_valid || i_pop);

    always_comb begin
        n_valid  = r_valid;
        n_word   = r_word;
        n_status = r_status;
        if (o_take) begin
            n_valid  = 1'b1;
            n_word   = (st == ST_OK) ? packed_word : w;
            n_status = st;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_status <= n_status;
    end

    assign o_empty        = !r_valid;
    assign o_patched_word = r_word;
    assign o_status       = r_status;

endmodule

`default_nettype wire

### design/aerp_checker.sv
// Port-level checker of the relocation patcher and its bind.
`default_nettype none
`include "arm_elf_relocation_patcher_assert.svh"

module aerp_checker #(
    parameter int P_QDEPTH = 4
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_patched_word,
    input wire logic [1:0]  o_status
);

    localparam int CW = $clog2(P_QDEPTH + 2);

    logic [CW-1:0] r_inflight;
    logic [CW-1:0] n_inflight;
    logic          acc_in;
    logic          acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    always_comb begin
        n_inflight = r_inflight;
        if (acc_in && !acc_out) begin
            n_inflight = r_inflight + 1'b1;
        end else if (acc_out && !acc_in) begin
            n_inflight = r_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `AERP_ASSERT_RST(a_reset_clears, !i_rst_n, empty && !full)
    `AERP_ASSERT_NOW(a_no_invented, !empty, r_inflight != '0)
    `AERP_ASSERT_NOW(a_full_only_when_held, full, r_inflight >= CW'(P_QDEPTH))
    `AERP_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(o_patched_word) && $stable(o_status))

endmodule

bind arm_elf_relocation_patcher aerp_checker #(
    .P_QDEPTH (P_QDEPTH)
) u_aerp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_patched_word (o_patched_word),
    .o_status       (o_status)
);

`default_nettype wire

### dv/aerp_patch_checker.sv
`timescale 1ns / 100ps
// Checker for the relocation patcher: predicts each request and compares its result.
module aerp_patch_checker
    import aerp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [4:0]  i_action,
    input  wire logic [31:0] i_place_word,
    input  wire logic [31:0] i_symbol_value,
    input  wire logic [31:0] i_place_address,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [31:0] i_patched_word,
    input  wire logic [1:0]  i_status,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0]  word;
        t_aerp_status status;
    } t_patch;

    t_patch expected_patches[$];
    int     fail_count = 0;
    int     pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [31:0] sign_ext(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        v = v & ((m << 1) - 32'd1);
        return (v ^ m) - m;
    endfunction

    function automatic logic fits_signed(input logic [31:0] v, input int bits);
        return sign_ext(v, bits) == v;
    endfunction

    function automatic t_patch patch_relocation(input logic [4:0] act, input logic [31:0] w,
                                                input logic [31:0] s, input logic [31:0] p);
        t_patch       r;
        logic         thumb;
        logic [15:0]  up;
        logic [15:0]  lo;
        logic [31:0]  res;
        logic [31:0]  a;
        logic [31:0]  x;
        logic [31:0]  ins;
        logic         sg;
        logic         j1;
        logic         j2;
        t_aerp_status st;
        thumb = s[0];
        up    = w[15:0];
        lo    = w[31:16];
        res   = w;
        st    = ST_OK;
        case (act)
            A_NONE, A_V4BX: begin
            end
            A_PREL31: begin
                a = sign_ext({1'b0, w[30:0]}, 31);
                x = ((s + a) | {31'd0, s[0]}) - p;
                if (!fits_signed(x, 31)) st = ST_OVERFLOW;
                else res = {w[31], x[30:0]};
            end
            A_PC24, A_CALL, A_JUMP24: begin
                ins = w;
                // Thumb target: keep BLX, turn an unconditional BL into BLX, reject the rest
                if (thumb && w[31:25] != BLX_MASKED) begin
                    if (w[31:24] == BL_AL_TOP) ins = {BLX_TOP, w[23:0]};
                    else st = ST_INTERWORK;
                end
                if (st == ST_OK) begin
                    a   = sign_ext({8'd0, w[23:0]}, 24) << 2;
                    x   = (s + a - p) >> 2;
                    res = {ins[31:24], x[23:0]};
                end
            end
            A_MOVT, A_MOVW: begin
                a = sign_ext({16'd0, w[19:16], w[11:0]}, 16);
                x = s + a;
                if (act == A_MOVT) x = x >> 16;
                res = {w[31:20], x[15:12], w[15:12], x[11:0]};
            end
            A_REL32, A_ABS32, A_GLOB_DAT: begin
                x = (w + s) | {31'd0, s[0]};
                if (act == A_REL32) x = x - p;
                res = x;
            end
            A_THM_MOVT, A_THM_MOVW: begin
                a = sign_ext({16'd0, up[3:0], up[10], lo[14:12], lo[7:0]}, 16);
                x = s + a;
                if (act == A_THM_MOVT) x = x >> 16;
                up  = {up[15:11], x[11], up[9:4], x[15:12]};
                lo  = {lo[15], x[10:8], lo[11:8], x[7:0]};
                res = {lo, up};
            end
            A_THM_JUMP24, A_THM_CALL: begin
                sg = up[10];
                j1 = ~(lo[13] ^ sg);
                j2 = ~(lo[11] ^ sg);
                a  = sign_ext({7'd0, sg, j1, j2, up[9:0], lo[10:0], 1'b0}, 25);
                if (!thumb) begin
                    // ARM target: a call becomes BLX, a plain branch cannot switch
                    if (act == A_THM_JUMP24) st = ST_INTERWORK;
                    else lo[12] = 1'b0;
                end
                if (st == ST_OK) begin
                    x = s + a - p;
                    if (!fits_signed(x, 25)) st = ST_OVERFLOW;
                    else begin
                        sg  = x[24];
                        up  = {up[15:11], sg, x[21:12]};
                        lo  = {lo[15:14], sg ^ ~x[23], lo[12], sg ^ ~x[22], x[11:1]};
                        res = {lo, up};
                    end
                end
            end
            A_THM_JUMP19: begin
                if (!thumb) st = ST_INTERWORK;
                else if (up[9:7] == T2_COND_AL) st = ST_UNKNOWN;
                else begin
                    a = sign_ext({11'd0, up[10], lo[11], lo[13], up[5:0], lo[10:0], 1'b0}, 21);
                    x = s + a - p;
                    if (!fits_signed(x, 21)) st = ST_OVERFLOW;
                    else begin
                        up  = {up[15:11], x[20], up[9:6], x[17:12]};
                        lo  = {lo[15:14], x[18], lo[12], x[19], x[11:1]};
                        res = {lo, up};
                    end
                end
            end
            A_THM_ABS5: begin
                a = {25'd0, up[10:6], 2'b00};
                x = s + a;
                if (x > 32'h7f) st = ST_OVERFLOW;
                else res = {w[31:11], x[6:2], w[5:0]};
            end
            A_THM_JUMP6: begin
                a = {25'd0, up[9], up[7:3], 1'b0};
                x = s + a - p;
                // unsigned range 0..127; negatives wrap far above it
                if (x > 32'd127) st = ST_OVERFLOW;
                else res = {w[31:10], x[6], w[8], x[5:1], w[2:0]};
            end
            A_THM_JUMP11: begin
                a = sign_ext({21'd0, up[10:0]}, 11) << 1;
                x = s + a - p;
                if (!fits_signed(x, 12)) st = ST_OVERFLOW;
                else res = {w[31:11], x[11:1]};
            end
            A_THM_JUMP8: begin
                a = sign_ext({24'd0, up[7:0]}, 8) << 1;
                x = s + a - p;
                if (!fits_signed(x, 9)) st = ST_OVERFLOW;
                else res = {w[31:8], x[8:1]};
            end
            default: begin
                st = ST_UNKNOWN;
            end
        endcase
        if (st != ST_OK) res = w;
        r.word   = res;
        r.status = st;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_patch want;
        if (!i_rst_n) begin
            expected_patches.delete();
        end else begin
            // retire before accepting, so a result never meets its own request
            if (i_pop && !i_empty) begin
                if (expected_patches.size() == 0) begin
                    $error("result with no request pending: patched_word %h status %0d",
                           i_patched_word, i_status);
                    fail_count++;
                end else begin
                    want = expected_patches.pop_front();
                    if (i_patched_word !== want.word) begin
                        $error("patched_word: expected %h, got %h", want.word, i_patched_word);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                expected_patches.push_back(patch_relocation(i_action, i_place_word,
                                                            i_symbol_value, i_place_address));
            end
        end
        pending_count = expected_patches.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the relocation patcher: stimulus, flow control and verdict.
module tb_top;
    import aerp_pkg::*;

    localparam int         RANDOM_REQUESTS      = 822;
    localparam int         CALM_TAIL_REQUESTS   = 120;
    localparam int         LONG_HOLD_CYCLES     = 80;
    localparam logic [4:0] FIRST_UNKNOWN_ACTION = 5'd20;
    localparam logic [4:0] LAST_UNKNOWN_ACTION  = 5'd31;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [4:0]  i_action;
    logic [31:0] i_place_word;
    logic [31:0] i_symbol_value;
    logic [31:0] i_place_address;
    logic        empty;
    logic        pop;
    logic [31:0] o_patched_word;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    bit calm_tail = 1'b0;

    always #6 i_clk = ~i_clk;

    arm_elf_relocation_patcher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_place_word   (i_place_word),
        .i_symbol_value (i_symbol_value),
        .i_place_address(i_place_address),
        .empty          (empty),
        .pop            (pop),
        .o_patched_word (o_patched_word),
        .o_status       (o_status)
    );

    aerp_patch_checker patch_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_action       (i_action),
        .i_place_word   (i_place_word),
        .i_symbol_value (i_symbol_value),
        .i_place_address(i_place_address),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_patched_word (o_patched_word),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic [4:0] act, input logic [31:0] w,
                                input logic [31:0] s, input logic [31:0] p);
        push            <= 1'b1;
        i_action        <= act;
        i_place_word    <= w;
        i_symbol_value  <= s;
        i_place_address <= p;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic make_request(output logic [4:0] act, output logic [31:0] w,
                                output logic [31:0] s, output logic [31:0] p);
        int span;
        if ($urandom_range(0, 9) == 0)
            act = 5'($urandom_range(FIRST_UNKNOWN_ACTION, LAST_UNKNOWN_ACTION));
        else
            act = 5'($urandom_range(A_NONE, A_THM_JUMP8));
        w    = $urandom;
        s    = $urandom;
        p    = $urandom;
        span = 0;
        case (act)
            A_PC24, A_CALL, A_JUMP24: begin
                case ($urandom_range(0, 3))
                    0: w[31:25] = BLX_MASKED;
                    1: w[31:24] = BL_AL_TOP;
                    default: ;
                endcase
            end
            A_THM_JUMP24, A_THM_CALL: span = 1 << 25;
            A_THM_JUMP19:             span = 1 << 21;
            A_THM_JUMP6:              span = 128;
            A_THM_JUMP11:             span = 1 << 12;
            A_THM_JUMP8:              span = 1 << 9;
            A_THM_ABS5: begin
                if ($urandom_range(0, 7) != 0) s = $urandom_range(0, 32'h60);
            end
            default: ;
        endcase
        // keep most branch targets near the place so range checks go both ways
        if (span != 0 && $urandom_range(0, 7) != 0)
            s = p + 32'($urandom_range(0, 2 * span)) - 32'(span);
        if (act == A_THM_JUMP24 || act == A_THM_CALL || act == A_THM_JUMP19)
            s[0] = ($urandom_range(0, 3) != 0);
    endtask

    initial begin : watchdog
        #5_000_000;
        $display("arm_elf_relocation_patcher test failed");
        $finish;
    end

    initial begin : receiver
        int stall_left;
        int taken;
        bit long_hold_done;
        stall_left     = 0;
        taken          = 0;
        long_hold_done = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) taken++;
            if (!long_hold_done && taken >= 200) begin
                // hold off long enough for the block to fill and raise full
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && !calm_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : sender
        logic [4:0]  act;
        logic [31:0] w;
        logic [31:0] s;
        logic [31:0] p;
        push            <= 1'b0;
        i_action        <= '0;
        i_place_word    <= '0;
        i_symbol_value  <= '0;
        i_place_address <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(A_NONE, '1, '1, '1);
        send_request(A_PREL31, 32'h0000_0000, 32'h0000_1001, 32'h0000_0000);
        send_request(A_PREL31, 32'hbfff_ffff, 32'h4000_0000, 32'h0000_0000);
        send_request(A_PC24, 32'heb00_0010, 32'h0000_8001, 32'h0000_0100);
        send_request(A_CALL, 32'hfb00_0000, 32'h0000_2001, 32'h0000_0000);
        send_request(A_JUMP24, 32'hea00_0000, 32'h0000_3001, 32'h0000_0000);
        send_request(A_V4BX, '1, 32'h0000_0000, 32'h0000_0000);
        send_request(A_MOVT, 32'he340_0000, 32'h1234_5678, 32'h0000_0000);
        send_request(A_MOVW, '1, '1, '1);
        send_request(A_REL32, 32'h0000_0000, 32'h0000_1001, 32'h0000_2000);
        send_request(A_ABS32, '1, 32'h0000_0001, 32'h0000_0000);
        send_request(A_GLOB_DAT, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        send_request(A_THM_MOVT, 32'h0000_f2c0, 32'hdead_beef, 32'h0000_0000);
        send_request(A_THM_MOVW, '1, 32'h0000_0000, 32'h0000_0000);
        send_request(A_THM_JUMP24, 32'h9000_f000, 32'h0010_0001, 32'h0000_0000);
        send_request(A_THM_JUMP24, 32'h9000_f000, 32'h0010_0000, 32'h0000_0000);
        send_request(A_THM_CALL, 32'hd000_f000, 32'h0000_4000, 32'h0000_0000);
        send_request(A_THM_CALL, 32'hd000_f000, 32'h0200_0001, 32'h0000_0000);
        send_request(A_THM_JUMP19, 32'h8000_f000, 32'h0000_0101, 32'h0000_0000);
        send_request(A_THM_JUMP19, 32'h8000_f380, 32'h0000_0001, 32'h0000_0000);
        send_request(A_THM_JUMP19, 32'h8000_f000, 32'h0000_0100, 32'h0000_0000);
        send_request(A_THM_ABS5, 32'h0000_07c0, 32'h0000_0000, 32'h0000_0000);
        send_request(A_THM_ABS5, 32'h0000_0000, 32'h0000_0080, 32'h0000_0000);
        send_request(A_THM_JUMP6, 32'h0000_0000, 32'h0000_007f, 32'h0000_0000);
        send_request(A_THM_JUMP6, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_request(A_THM_JUMP11, 32'h0000_03ff, 32'h0000_0000, 32'h0000_0000);
        send_request(A_THM_JUMP8, 32'hffff_ff80, 32'h0000_0000, 32'h0000_0000);
        send_request(FIRST_UNKNOWN_ACTION, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(LAST_UNKNOWN_ACTION, '1, '1, '1);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm_tail = (n >= RANDOM_REQUESTS - CALM_TAIL_REQUESTS);
            if (n == 400) begin
                drain_results();
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            make_request(act, w, s, p);
            send_request(act, w, s, p);
        end
        drain_results();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0)
            $display("arm_elf_relocation_patcher test passed");
        else
            $display("arm_elf_relocation_patcher test failed");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/aerp_pkg.sv
design/aerp_front.sv
design/aerp_queue.sv
design/aerp_back.sv
design/arm_elf_relocation_patcher.sv
design/aerp_checker.sv
dv/aerp_patch_checker.sv
dv/tb_top.sv
